// ===== sv/frs_pkg.sv =====
package frs_pkg;

    localparam int COUNT_BITS  = 32;
    localparam int LENGTH_BITS = 16;
    localparam int HASH_BITS   = 64;
    localparam int DIV_BITS    = 32;
    localparam int NUM_SYMS    = 5;
    localparam int STEP_BITS   = $clog2(HASH_BITS);

    localparam logic [HASH_BITS-1:0] HASH_SEED = HASH_BITS'(5381);

    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_C_UP = 8'h43;
    localparam logic [7:0] CH_G_UP = 8'h47;
    localparam logic [7:0] CH_T_UP = 8'h54;
    localparam logic [7:0] CH_A_LO = 8'h61;
    localparam logic [7:0] CH_C_LO = 8'h63;
    localparam logic [7:0] CH_G_LO = 8'h67;
    localparam logic [7:0] CH_T_LO = 8'h74;

    // symbol lane order
    localparam int SYM_A     = 0;
    localparam int SYM_C     = 1;
    localparam int SYM_G     = 2;
    localparam int SYM_T     = 3;
    localparam int SYM_OTHER = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [HASH_BITS-1:0]   id_hash;
        logic [DIV_BITS-1:0]    bucket;
        logic [LENGTH_BITS-1:0] id_length;
        logic [COUNT_BITS-1:0]  total_count;
        logic [COUNT_BITS-1:0]  count_a;
        logic [COUNT_BITS-1:0]  count_c;
        logic [COUNT_BITS-1:0]  count_g;
        logic [COUNT_BITS-1:0]  count_t;
        logic [COUNT_BITS-1:0]  count_other;
        logic                   last_in_run;
    } t_out_item;

    // record summary before the bucket is known
    typedef struct packed {
        logic [HASH_BITS-1:0]   id_hash;
        logic [LENGTH_BITS-1:0] id_length;
        logic [COUNT_BITS-1:0]  total_count;
        logic [COUNT_BITS-1:0]  count_a;
        logic [COUNT_BITS-1:0]  count_c;
        logic [COUNT_BITS-1:0]  count_g;
        logic [COUNT_BITS-1:0]  count_t;
        logic [COUNT_BITS-1:0]  count_other;
    } t_summary;

    localparam t_summary EMPTY_SUMMARY = '{
        id_hash: HASH_SEED, id_length: '0, total_count: '0, count_a: '0,
        count_c: '0, count_g: '0, count_t: '0, count_other: '0
    };

    typedef struct packed {
        logic emit_first;
        logic emit_second;
    } t_trk_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

endpackage

// ===== sv/frs_mod_unit.sv =====
module frs_mod_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [frs_pkg::HASH_BITS-1:0] i_dividend,
    input  logic [frs_pkg::DIV_BITS-1:0]  i_divisor,
    output logic                          o_done,
    output logic [frs_pkg::DIV_BITS-1:0]  o_rem
);
    import frs_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_count;
    logic [HASH_BITS-1:0] r_dvd;
    logic [DIV_BITS-1:0]  r_div;
    logic [DIV_BITS-1:0]  r_rem;
    logic [DIV_BITS:0]    trial;
    logic [DIV_BITS-1:0]  n_rem;

    // one restoring step per cycle, msb first
    always_comb begin
        trial = {r_rem, r_dvd[HASH_BITS-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = DIV_BITS'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[DIV_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 1'b1;
                if (r_count == STEP_BITS'(HASH_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[HASH_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = (r_div == '0) ? '0 : r_rem;

endmodule

// ===== sv/frs_tracker.sv =====
module frs_tracker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  frs_pkg::t_in_item     i_item,
    output frs_pkg::t_summary     o_first,
    output frs_pkg::t_trk_status  o_status
);
    import frs_pkg::*;

    logic                   r_open, r_in_id, r_line_start;
    logic [HASH_BITS-1:0]   r_hash;
    logic [LENGTH_BITS-1:0] r_len;
    logic [COUNT_BITS-1:0]  r_total;
    logic [COUNT_BITS-1:0]  r_sym [NUM_SYMS];

    logic                   n_open, n_in_id, n_line_start;
    logic [HASH_BITS-1:0]   n_hash;
    logic [LENGTH_BITS-1:0] n_len;
    logic [COUNT_BITS-1:0]  n_total;
    logic [COUNT_BITS-1:0]  n_sym [NUM_SYMS];

    logic                   gt_start;
    logic [NUM_SYMS-1:0]    sym_hit;
    t_summary               cur_sum, upd_sum;

    always_comb begin
        sym_hit = '0;
        case (i_item.data_byte) inside
            CH_A_UP, CH_A_LO: sym_hit[SYM_A] = 1'b1;
            CH_C_UP, CH_C_LO: sym_hit[SYM_C] = 1'b1;
            CH_G_UP, CH_G_LO: sym_hit[SYM_G] = 1'b1;
            CH_T_UP, CH_T_LO: sym_hit[SYM_T] = 1'b1;
            default:          sym_hit[SYM_OTHER] = 1'b1;
        endcase
    end

    assign gt_start = (i_item.data_byte == CH_GT) && r_line_start;

    always_comb begin
        n_open       = r_open;
        n_in_id      = r_in_id;
        n_line_start = r_line_start;
        n_hash       = r_hash;
        n_len        = r_len;
        n_total      = r_total;
        n_sym        = r_sym;
        if (i_item.data_byte == CH_NL) begin
            n_in_id      = 1'b0;
            n_line_start = 1'b1;
        end else if (gt_start) begin
            n_hash       = HASH_SEED;
            n_len        = '0;
            n_total      = '0;
            for (int k = 0; k < NUM_SYMS; k++) n_sym[k] = '0;
            n_open       = 1'b1;
            n_in_id      = 1'b1;
            n_line_start = 1'b0;
        end else begin
            n_line_start = 1'b0;
            if (i_item.data_byte == CH_GT) begin
                // stray '>' mid-line, dropped
            end else if (r_in_id) begin
                n_hash = r_hash + {r_hash[HASH_BITS-6:0], 5'b0}
                       + {{(HASH_BITS-8){1'b0}}, i_item.data_byte};
                if (r_len != '1) n_len = r_len + 1'b1;
            end else if (r_open) begin
                if (r_total != '1) n_total = r_total + 1'b1;
                for (int k = 0; k < NUM_SYMS; k++) begin
                    if (sym_hit[k] && r_sym[k] != '1) n_sym[k] = r_sym[k] + 1'b1;
                end
            end
        end
    end

    always_comb begin
        cur_sum = '{id_hash: r_hash, id_length: r_len, total_count: r_total,
                    count_a: r_sym[SYM_A], count_c: r_sym[SYM_C],
                    count_g: r_sym[SYM_G], count_t: r_sym[SYM_T],
                    count_other: r_sym[SYM_OTHER]};
        upd_sum = '{id_hash: n_hash, id_length: n_len, total_count: n_total,
                    count_a: n_sym[SYM_A], count_c: n_sym[SYM_C],
                    count_g: n_sym[SYM_G], count_t: n_sym[SYM_T],
                    count_other: n_sym[SYM_OTHER]};
    end

    // a new header closes the old record before anything else
    assign o_first = (gt_start && r_open) ? cur_sum : upd_sum;
    assign o_status.emit_first  = (gt_start && r_open) || (i_item.final_byte && n_open);
    assign o_status.emit_second = gt_start && r_open && i_item.final_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_item.final_byte)) begin
            r_open       <= 1'b0;
            r_in_id      <= 1'b0;
            r_line_start <= 1'b1;
            r_hash       <= HASH_SEED;
            r_len        <= '0;
            r_total      <= '0;
            for (int k = 0; k < NUM_SYMS; k++) r_sym[k] <= '0;
        end else if (i_accept) begin
            r_open       <= n_open;
            r_in_id      <= n_in_id;
            r_line_start <= n_line_start;
            r_hash       <= n_hash;
            r_len        <= n_len;
            r_total      <= n_total;
            r_sym        <= n_sym;
        end
    end

endmodule

// ===== sv/fasta_record_summarizer_top.sv =====
// channel   | direction | handshake                   | payload
// ----------+-----------+-----------------------------+-----------------------------
// input     | in        | i_in_valid / o_in_stall     | i_in_data  (t_in_item)
// output    | out       | o_out_valid / i_out_stall   | o_out_data (t_out_item)
// config    | in        | i_cfg_valid / o_cfg_ready   | i_cfg_data (table_size)
//
// a byte that closes no record leaves the block idle and ready for the next byte
// a closing byte runs the shared remainder unit for 64 steps before the record is
// offered, and the next byte is taken only after that record has been taken
// a header on the final byte emits two records, the second after the first is taken
// o_in_stall is high from the accepting edge until the last record is taken, and
// output stalls lengthen it; synchronous active-low reset, stream resets on final byte
module fasta_record_summarizer_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  frs_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output frs_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [frs_pkg::DIV_BITS-1:0] i_cfg_data
);
    import frs_pkg::*;

    t_state                r_state, n_state;
    logic                  r_second;
    logic                  r_last;
    t_summary              r_res;
    logic [DIV_BITS-1:0]   r_bucket;
    logic [DIV_BITS-1:0]   r_table_size;

    logic                  in_accept;
    logic                  out_take;
    logic                  mod_start;
    logic                  mod_done;
    logic [DIV_BITS-1:0]   mod_rem;
    logic [HASH_BITS-1:0]  mod_dividend;
    t_summary              trk_first;
    t_trk_status           trk_status;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take  = o_out_valid && !i_out_stall;

    // stream parsing and running counts
    frs_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .o_first  (trk_first),
        .o_status (trk_status)
    );

    // bucket: one division step a cycle; the second record of a run is always empty
    assign mod_start    = (in_accept && trk_status.emit_first) || (out_take && r_second);
    assign mod_dividend = (r_state == S_IDLE) ? trk_first.id_hash : HASH_SEED;

    frs_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (r_table_size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_accept && trk_status.emit_first) n_state = S_DIV;
            S_DIV:  if (mod_done) n_state = S_OUT;
            S_OUT: begin
                if (out_take) n_state = r_second ? S_DIV : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_second     <= 1'b0;
            r_table_size <= DIV_BITS'(1024);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_table_size <= i_cfg_data;
            if (in_accept && trk_status.emit_first) begin
                r_second <= trk_status.emit_second;
            end else if (out_take) begin
                r_second <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept && trk_status.emit_first) begin
            r_res  <= trk_first;
            r_last <= !trk_status.emit_second;
        end else if (out_take && r_second) begin
            r_res  <= EMPTY_SUMMARY;
            r_last <= 1'b1;
        end
        if (mod_done) r_bucket <= mod_rem;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_out_data.id_hash     = r_res.id_hash;
        o_out_data.bucket      = r_bucket;
        o_out_data.id_length   = r_res.id_length;
        o_out_data.total_count = r_res.total_count;
        o_out_data.count_a     = r_res.count_a;
        o_out_data.count_c     = r_res.count_c;
        o_out_data.count_g     = r_res.count_g;
        o_out_data.count_t     = r_res.count_t;
        o_out_data.count_other = r_res.count_other;
        o_out_data.last_in_run = r_last;
    end

    // no new byte while a record is on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_accept && o_out_valid))
        else $error("input taken while output valid");

    // bucket stays below a non-zero table size
    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_table_size != '0) |-> (o_out_data.bucket < r_table_size))
        else $error("bucket out of range");

    // a pending second record means this one is not the last
    a_second_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_second) |-> !o_out_data.last_in_run)
        else $error("last_in_run set with a record still pending");

    // the remainder unit finishes only while the sequencer waits for it
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == S_DIV))
        else $error("remainder done outside division state");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import frs_pkg::*;

    // timing of the run
    localparam int  SETTLE_CYCLES = 150;       // covers a header on the final byte
    localparam int  CYCLE_LIMIT   = 4_000_000;
    localparam int  LONG_ID_BYTES = 80;        // wraps the hash many times over
    localparam int  DIRECTED_ROWS = 25;

    // one row of the directed table; answer fields are used only where has_answer is set
    typedef struct packed {
        logic [7:0]             data_byte;
        logic                   final_byte;
        logic                   has_answer;
        logic [1:0]             answer_count;
        logic [HASH_BITS-1:0]   ans_hash;
        logic [DIV_BITS-1:0]    ans_bucket;
        logic [LENGTH_BITS-1:0] ans_len;
    } t_dir_row;

    // one byte waiting to be sent, with an optional fixed answer
    typedef struct {
        t_in_item  item;
        bit        has_answer;
        int        answer_count;
        t_out_item answer;
    } t_byte_req;

    // directed bytes: empty record at reset, zero and 0xff in the id, a '>' that is
    // not at a line start, all four bases in mixed case, carriage return, a header on the
    // final byte, bytes before any record and a final byte with no record open
    localparam t_dir_row DIRECTED [DIRECTED_ROWS] = '{
        '{CH_GT,   1'b1, 1'b1, 2'd1, 64'd5381,   32'd261, 16'd0},
        '{CH_GT,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{8'h00,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{8'hFF,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_GT,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_NL,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_A_UP, 1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_C_LO, 1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_G_UP, 1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_T_LO, 1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{8'h0D,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{8'h78,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_GT,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_NL,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_GT,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{8'h71,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_NL,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_T_UP, 1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_NL,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_GT,   1'b1, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_A_UP, 1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_NL,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_A_LO, 1'b1, 1'b1, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_GT,   1'b0, 1'b0, 2'd0, 64'd0,      32'd0,   16'd0},
        '{CH_G_LO, 1'b1, 1'b1, 2'd1, 64'd177676, 32'd524, 16'd1}
    };

    // dut ports
    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [DIV_BITS-1:0] i_cfg_data  = '0;

    // predictor state: stream position and the record being built
    logic                   rec_open;
    logic                   in_header;
    logic                   line_start;
    logic [HASH_BITS-1:0]   run_hash;
    logic [LENGTH_BITS-1:0] run_len;
    logic [COUNT_BITS-1:0]  run_total;
    logic [COUNT_BITS-1:0]  sym_cnt [NUM_SYMS];
    logic [DIV_BITS-1:0]    bucket_count;

    t_byte_req  byte_feed [$];
    t_out_item  pending_summaries [$];

    int  errors       = 0;
    int  n_bytes      = 0;
    int  n_summaries  = 0;
    int  n_sizes      = 0;
    int  n_holds      = 0;
    int  cycles       = 0;
    int  stall_left   = 0;
    bit  idle_on      = 1'b1;
    bit  quiet_spell  = 1'b0;

    fasta_record_summarizer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_record();
        run_hash  = HASH_SEED;
        run_len   = '0;
        run_total = '0;
        foreach (sym_cnt[k]) sym_cnt[k] = '0;
    endfunction

    function automatic void reset_stream();
        rec_open   = 1'b0;
        in_header  = 1'b0;
        line_start = 1'b1;
        clear_record();
    endfunction

    // summary of the open record as the block presents it
    function automatic t_out_item record_summary(input logic last);
        t_out_item r;
        r.id_hash     = run_hash;
        r.bucket      = (bucket_count == '0) ? '0 :
                        DIV_BITS'(run_hash % {32'd0, bucket_count});
        r.id_length   = run_len;
        r.total_count = run_total;
        r.count_a     = sym_cnt[SYM_A];
        r.count_c     = sym_cnt[SYM_C];
        r.count_g     = sym_cnt[SYM_G];
        r.count_t     = sym_cnt[SYM_T];
        r.count_other = sym_cnt[SYM_OTHER];
        r.last_in_run = last;
        return r;
    endfunction

    // folds one byte into the stream state, appending the summaries it closes
    function automatic void summarize_byte(input t_in_item it, ref t_out_item res [$]);
        int lane;
        if (it.data_byte == CH_NL) begin
            in_header  = 1'b0;
            line_start = 1'b1;
        end else if (it.data_byte == CH_GT && line_start) begin
            // a header on the final byte is followed by the empty record's summary
            if (rec_open) res.push_back(record_summary(!it.final_byte));
            clear_record();
            rec_open   = 1'b1;
            in_header  = 1'b1;
            line_start = 1'b0;
        end else begin
            line_start = 1'b0;
            if (it.data_byte == CH_GT) begin
                // stray '>' is dropped
            end else if (in_header) begin
                run_hash = run_hash * 64'd33 + {56'd0, it.data_byte};
                if (run_len != '1) run_len++;
            end else if (rec_open) begin
                if (run_total != '1) run_total++;
                case (it.data_byte)
                    CH_A_UP, CH_A_LO: lane = SYM_A;
                    CH_C_UP, CH_C_LO: lane = SYM_C;
                    CH_G_UP, CH_G_LO: lane = SYM_G;
                    CH_T_UP, CH_T_LO: lane = SYM_T;
                    default:          lane = SYM_OTHER;
                endcase
                if (sym_cnt[lane] != '1) sym_cnt[lane]++;
            end
        end
        if (it.final_byte) begin
            if (rec_open) res.push_back(record_summary(1'b1));
            reset_stream();
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void put_byte(input logic [7:0] b, input logic fin);
        t_byte_req r;
        r.item.data_byte  = b;
        r.item.final_byte = fin;
        r.has_answer      = 1'b0;
        r.answer_count    = 0;
        r.answer          = '0;
        byte_feed.push_back(r);
    endfunction

    function automatic logic [7:0] id_char();
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic logic [7:0] seq_char();
        logic [7:0] bases [8] = '{CH_A_UP, CH_C_UP, CH_G_UP, CH_T_UP,
                                  CH_A_LO, CH_C_LO, CH_G_LO, CH_T_LO};
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8)   return bases[pick];
        if (pick == 8)  return 8'h4E;                 // N
        if (pick == 9)  return 8'h0D;                 // carriage return
        if (pick == 10) return CH_GT;                 // '>' mid line
        if (pick == 11) return 8'($urandom_range(0, 255));
        return bases[$urandom_range(0, 3)];
    endfunction

    // mostly well formed streams of records, with some noise and cut-off streams
    task automatic queue_text(input int budget);
        logic [7:0] text [$];
        int target;
        int end_kind;
        target = byte_feed.size() + budget;
        while (byte_feed.size() < target) begin
            text.delete();
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6))
                    put_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 4)) text.push_back(seq_char());
                    text.push_back(CH_NL);
                end
                repeat ($urandom_range(1, 3)) begin
                    text.push_back(CH_GT);
                    repeat ($urandom_range(0, 10)) text.push_back(id_char());
                    text.push_back(CH_NL);
                    repeat ($urandom_range(0, 3)) begin
                        repeat ($urandom_range(0, 16)) text.push_back(seq_char());
                        text.push_back(CH_NL);
                    end
                end
                end_kind = $urandom_range(0, 7);
                if (end_kind == 0) begin
                    text.push_back(CH_GT);
                end else if (end_kind == 1) begin
                    text.push_back(CH_GT);
                    repeat ($urandom_range(1, 4)) text.push_back(id_char());
                end
                // kind 2 leaves the stream open so the next header closes the record
                foreach (text[k])
                    put_byte(text[k], end_kind != 2 && k == text.size() - 1);
            end
        end
    endtask

    // sends the queued bytes, predicting each one as it is taken
    task automatic send_feed();
        t_byte_req  req;
        t_out_item  got [$];
        int         gap;
        bit         hold;
        while (byte_feed.size() > 0) begin
            req = byte_feed.pop_front();
            i_in_valid <= 1'b1;
            i_in_data  <= req.item;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            got.delete();
            summarize_byte(req.item, got);
            if (req.has_answer) begin
                if (req.answer_count > 0) pending_summaries.push_back(req.answer);
            end else begin
                foreach (got[k]) pending_summaries.push_back(got[k]);
            end
            n_bytes++;
            hold = idle_on && ($urandom_range(0, 63) == 0 || n_bytes == 100);
            gap  = (idle_on && !quiet_spell && $urandom_range(0, 3) == 0) ?
                   $urandom_range(1, 8) : 0;
            if (hold || gap > 0 || byte_feed.size() == 0) begin
                i_in_valid <= 1'b0;
                if (hold) begin
                    // let the block run dry before the next byte
                    n_holds++;
                    @(posedge i_clk);
                    while (pending_summaries.size() != 0) @(posedge i_clk);
                end else begin
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    // table size changes only once every summary is out and the block has settled
    task automatic program_table_size(input logic [DIV_BITS-1:0] size);
        while (pending_summaries.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        bucket_count = size;
        n_sizes++;
    endtask

    // ---------------------------------------------------------------- checking

    function automatic int field_diff(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
        if (want === got) return 0;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        return 1;
    endfunction

    // compares each output transaction with the oldest pending summary and paces stall
    always @(posedge i_clk) begin
        t_out_item want;
        bit        stall_next;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_summaries.size() == 0) begin
                $display("%0t: unexpected summary, expected none, actual hash %0h",
                         $time, o_out_data.id_hash);
                errors++;
            end else begin
                want = pending_summaries.pop_front();
                errors += field_diff("id_hash", want.id_hash, o_out_data.id_hash);
                errors += field_diff("bucket", want.bucket, o_out_data.bucket);
                errors += field_diff("id_length", want.id_length, o_out_data.id_length);
                errors += field_diff("total_count", want.total_count,
                                     o_out_data.total_count);
                errors += field_diff("count_a", want.count_a, o_out_data.count_a);
                errors += field_diff("count_c", want.count_c, o_out_data.count_c);
                errors += field_diff("count_g", want.count_g, o_out_data.count_g);
                errors += field_diff("count_t", want.count_t, o_out_data.count_t);
                errors += field_diff("count_other", want.count_other,
                                     o_out_data.count_other);
                errors += field_diff("last_in_run", want.last_in_run,
                                     o_out_data.last_in_run);
            end
            n_summaries++;
        end
        if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
        end else if (idle_on && !quiet_spell && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            stall_next = 1'b1;
        end else begin
            stall_next = 1'b0;
        end
        i_out_stall <= stall_next;
    end

    // watchdog, and the odd stretch with no idling on either side
    always @(posedge i_clk) begin
        cycles++;
        if ($urandom_range(0, 255) == 0) quiet_spell <= ~quiet_spell;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d summaries still pending",
                     cycles, pending_summaries.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        t_byte_req req;
        reset_stream();
        bucket_count = 32'd1024;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at the reset table size
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            req.item.data_byte          = DIRECTED[i].data_byte;
            req.item.final_byte         = DIRECTED[i].final_byte;
            req.has_answer              = DIRECTED[i].has_answer;
            req.answer_count            = DIRECTED[i].answer_count;
            req.answer                  = '0;
            req.answer.id_hash          = DIRECTED[i].ans_hash;
            req.answer.bucket           = DIRECTED[i].ans_bucket;
            req.answer.id_length        = DIRECTED[i].ans_len;
            req.answer.last_in_run      = 1'b1;
            byte_feed.push_back(req);
        end
        send_feed();

        // single bucket
        program_table_size(32'd1);
        queue_text(150);
        send_feed();

        // widest table, with one long id line
        program_table_size('1);
        queue_text(60);
        put_byte(CH_GT, 1'b0);
        repeat (LONG_ID_BYTES) put_byte(8'($urandom_range(33, 61)), 1'b0);
        put_byte(CH_NL, 1'b0);
        put_byte(CH_A_UP, 1'b0);
        put_byte(CH_C_UP, 1'b0);
        put_byte(CH_G_UP, 1'b0);
        put_byte(CH_T_UP, 1'b0);
        put_byte(CH_NL, 1'b1);
        queue_text(90);
        send_feed();

        // zero table size gives bucket zero
        program_table_size(32'd0);
        queue_text(60);
        send_feed();

        repeat (5) begin
            program_table_size($urandom_range(0, 1) ? 32'($urandom) :
                               32'($urandom_range(2, 100)));
            queue_text(120);
            send_feed();
        end

        // back to the reset size, both sides at full rate
        program_table_size(32'd1024);
        idle_on <= 1'b0;
        queue_text(150);
        send_feed();

        while (pending_summaries.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes over %0d table sizes, checked %0d record summaries",
                 n_bytes, n_sizes, n_summaries);
        $display("sender held off %0d times until the block ran dry", n_holds);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
